// ===== sv/sba_pkg.sv =====
// Package for the spectrum band averager: constants, payload structs and state enums.
`timescale 1ns / 1ps
`default_nettype none
package sba_pkg;

  localparam int unsigned MAX_BANDS_DEF   = 64;
  localparam int unsigned MAG_WIDTH_DEF   = 16;
  localparam int unsigned MAX_BANDS_LIMIT = 256;

  localparam int unsigned MAG_W        = 16;
  localparam int unsigned BAND_COUNT_W = 7;
  localparam int unsigned SPACING_W    = 11;
  localparam int unsigned POS_W        = 16;
  localparam int unsigned SUM_W        = 32;
  localparam int unsigned LEVEL_W      = 16;
  localparam int unsigned BAR_W        = 16;
  localparam int unsigned BAND_IDX_W   = 6;
  // divisor field sized for the largest band count allowed
  localparam int unsigned DIV_W        = SPACING_W + 2 * $clog2(MAX_BANDS_LIMIT + 1);

  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned LOG_E_W = 5;
  localparam int unsigned LOG_W   = LOG_E_W + FRAC_W;
  localparam int unsigned GAIN_W  = 20;
  localparam int unsigned PROD_W  = LOG_W + GAIN_W;
  localparam int unsigned STEP_W  = 4;

  // 0.2 / log2(10) in Q0.24
  localparam logic [GAIN_W-1:0] HEIGHT_GAIN = GAIN_W'(1010089);
  localparam int unsigned       ROUND_SHIFT = 24;

  localparam logic [BAND_COUNT_W-1:0] BAND_COUNT_RST = BAND_COUNT_W'(16);
  localparam logic [SPACING_W-1:0]    SPACING_RST    = SPACING_W'(1);

  localparam int unsigned JOB_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 2;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic {
    REG_BAND_COUNT = 1'b0,
    REG_SPACING    = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             last_bin;
  } in_t;

  typedef struct packed {
    logic [BAND_IDX_W-1:0] band_index;
    logic [LEVEL_W-1:0]    band_level;
    logic [BAR_W-1:0]      bar_height;
    logic                  last_band;
  } out_t;

  typedef struct packed {
    logic [BAND_IDX_W-1:0] band_index;
    logic [SUM_W-1:0]      sum;
    logic [DIV_W-1:0]      divisor;
    logic                  last_band;
  } job_t;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_SQUARE,
    FRONT_SCALE
  } front_state_e;

  typedef enum logic [2:0] {
    BACK_IDLE,
    BACK_SAT,
    BACK_DIV,
    BACK_NORM,
    BACK_SQR,
    BACK_GAIN,
    BACK_OUT
  } back_state_e;

endpackage
`default_nettype wire

// ===== sv/sba_fifo.sv =====
// Small synchronous queue on flip-flops.
`timescale 1ns / 1ps
`default_nettype none
module sba_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW:0]      wr_ptr_q, wr_ptr_d;
  logic [AW:0]      rd_ptr_q, rd_ptr_d;
  logic             do_push, do_pop;

  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign full_o  = (wr_ptr_q[AW] != rd_ptr_q[AW]) && (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q[AW-1:0]];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + (AW+1)'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q[AW-1:0]] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sba_front.sv =====
// Front end: bin accumulation, band edge tracking and job issue.
`timescale 1ns / 1ps
`default_nettype none
module sba_front #(
  parameter int unsigned MAX_BANDS = sba_pkg::MAX_BANDS_DEF,
  parameter int unsigned MAG_WIDTH = sba_pkg::MAG_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire sba_pkg::in_t                       in_data_i,
  input  wire logic                               push_i,
  output logic                                    full_o,
  input  wire logic [sba_pkg::BAND_COUNT_W-1:0]   band_count_i,
  input  wire logic [sba_pkg::SPACING_W-1:0]      spacing_i,
  output sba_pkg::job_t                           job_o,
  output logic                                    job_push_o,
  input  wire logic                               job_full_i,
  output logic                                    busy_o
);
  import sba_pkg::*;

  localparam int unsigned CB_W      = $clog2(MAX_BANDS + 1);
  localparam int unsigned SQ_W      = 2 * CB_W;
  localparam int unsigned EDGE_W    = SPACING_W + SQ_W;
  localparam int unsigned CMP_W     = (EDGE_W > POS_W) ? EDGE_W : POS_W;
  localparam int unsigned CNT_W     = (CB_W > BAND_COUNT_W) ? CB_W : BAND_COUNT_W;
  localparam int unsigned MAG_USE_W = (MAG_WIDTH < MAG_W) ? MAG_WIDTH : MAG_W;

  front_state_e      state_q, state_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              past_end_q, past_end_d;
  logic [CB_W-1:0]   band_q, band_d;
  logic [EDGE_W-1:0] edge_q, edge_d;
  logic [EDGE_W-1:0] prev_q, prev_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SQ_W-1:0]   sq_q, sq_d;

  logic [SUM_W-1:0]   mag;
  logic [CNT_W-1:0]   bc_ext;
  logic [CB_W-1:0]    eff;
  logic [SPACING_W-1:0] sp;
  logic               accept, active, hit;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_sat;
  logic [EDGE_W-1:0]  div;
  logic [CB_W:0]      band_inc;

  assign mag     = SUM_W'(in_data_i.magnitude[MAG_USE_W-1:0]);
  assign bc_ext  = CNT_W'(band_count_i);
  assign sp      = (spacing_i == '0) ? SPACING_W'(1) : spacing_i;
  assign full_o  = (state_q != FRONT_IDLE) || job_full_i;
  assign busy_o  = (state_q != FRONT_IDLE);
  assign accept  = push_i && !full_o;
  assign active  = !past_end_q && (band_q < eff);
  assign sum_add = {1'b0, sum_q} + {1'b0, mag};
  assign sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign hit     = active && (CMP_W'(pos_q) == CMP_W'(edge_q));
  assign band_inc = {1'b0, band_q} + (CB_W+1)'(1);

  always_comb begin
    if (bc_ext == '0) begin
      eff = CB_W'(1);
    end else if (bc_ext > CNT_W'(MAX_BANDS)) begin
      eff = CB_W'(MAX_BANDS);
    end else begin
      eff = CB_W'(bc_ext);
    end
  end

  always_comb begin
    if (band_q == '0 || edge_q <= prev_q) begin
      div = EDGE_W'(1);
    end else begin
      div = edge_q - prev_q;
    end
  end

  assign job_o.band_index = BAND_IDX_W'(band_q);
  assign job_o.sum        = sum_sat;
  assign job_o.divisor    = DIV_W'(div);
  assign job_o.last_band  = (band_inc == {1'b0, eff});
  assign job_push_o       = accept && hit;

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    past_end_d = past_end_q;
    band_d     = band_q;
    edge_d     = edge_q;
    prev_d     = prev_q;
    sum_d      = sum_q;
    sq_d       = sq_q;
    unique case (state_q)
      FRONT_IDLE: begin
        if (accept) begin
          if (active) begin
            sum_d = sum_sat;
            if (hit) begin
              sum_d   = mag;
              prev_d  = edge_q;
              band_d  = band_inc[CB_W-1:0];
              state_d = FRONT_SQUARE;
            end
          end
          if (!past_end_q) begin
            if (pos_q == '1) begin
              past_end_d = 1'b1;
            end else begin
              pos_d = pos_q + POS_W'(1);
            end
          end
          if (in_data_i.last_bin) begin
            state_d    = FRONT_IDLE;
            pos_d      = '0;
            past_end_d = 1'b0;
            band_d     = '0;
            edge_d     = '0;
            prev_d     = '0;
            sum_d      = '0;
          end
        end
      end
      FRONT_SQUARE: begin
        sq_d    = SQ_W'(band_q) * SQ_W'(band_q);
        state_d = FRONT_SCALE;
      end
      FRONT_SCALE: begin
        edge_d  = EDGE_W'(sp) * EDGE_W'(sq_q);
        state_d = FRONT_IDLE;
      end
      default: state_d = FRONT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FRONT_IDLE;
      pos_q      <= '0;
      past_end_q <= 1'b0;
      band_q     <= '0;
      edge_q     <= '0;
      prev_q     <= '0;
      sum_q      <= '0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      past_end_q <= past_end_d;
      band_q     <= band_d;
      edge_q     <= edge_d;
      prev_q     <= prev_d;
      sum_q      <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

endmodule
`default_nettype wire

// ===== sv/sba_back.sv =====
// Back end: restoring divide, log2 by mantissa squaring and height scaling.
`timescale 1ns / 1ps
`default_nettype none
module sba_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sba_pkg::job_t job_i,
  input  wire logic          job_empty_i,
  output logic               job_pop_o,
  output sba_pkg::out_t      res_o,
  output logic               res_push_o,
  input  wire logic          res_full_i
);
  import sba_pkg::*;

  localparam int unsigned DSH_W = DIV_W + LEVEL_W;
  localparam int unsigned V_W   = LEVEL_W + 1;

  back_state_e           state_q, state_d;
  logic [SUM_W-1:0]      rem_q, rem_d;
  logic [DSH_W-1:0]      dsh_q, dsh_d;
  logic [LEVEL_W-1:0]    quo_q, quo_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [BAND_IDX_W-1:0] idx_q, idx_d;
  logic                  last_q, last_d;
  logic [FRAC_W-1:0]     mant_q, mant_d;
  logic [LOG_W-1:0]      log_q, log_d;
  logic [PROD_W-1:0]     prod_q, prod_d;

  logic                  ge;
  logic [V_W-1:0]        v;
  logic [LOG_E_W-1:0]    e;
  logic [31:0]           vsh;
  logic [2*FRAC_W-1:0]   sq;
  logic [PROD_W-1:0]     rounded;

  assign ge      = (DSH_W'(rem_q) >= dsh_q);
  assign v       = {1'b0, quo_q} + V_W'(1);
  assign vsh     = 32'(v) << (LOG_E_W'(15) - e);
  assign sq      = (2*FRAC_W)'(mant_q) * (2*FRAC_W)'(mant_q);
  assign rounded = prod_q + (PROD_W'(1) << (ROUND_SHIFT - 1));

  always_comb begin
    e = '0;
    for (int i = 0; i < V_W; i++) begin
      if (v[i]) begin
        e = LOG_E_W'(i);
      end
    end
  end

  assign res_o.band_index = idx_q;
  assign res_o.band_level = quo_q;
  assign res_o.bar_height = rounded[ROUND_SHIFT +: BAR_W];
  assign res_o.last_band  = last_q;

  always_comb begin
    state_d    = state_q;
    rem_d      = rem_q;
    dsh_d      = dsh_q;
    quo_d      = quo_q;
    step_d     = step_q;
    idx_d      = idx_q;
    last_d     = last_q;
    mant_d     = mant_q;
    log_d      = log_q;
    prod_d     = prod_q;
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      BACK_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          rem_d     = job_i.sum;
          dsh_d     = {job_i.divisor, {LEVEL_W{1'b0}}};
          idx_d     = job_i.band_index;
          last_d    = job_i.last_band;
          state_d   = BACK_SAT;
        end
      end
      BACK_SAT: begin
        if (ge) begin
          quo_d   = '1;
          state_d = BACK_NORM;
        end else begin
          quo_d   = '0;
          dsh_d   = dsh_q >> 1;
          step_d  = '1;
          state_d = BACK_DIV;
        end
      end
      BACK_DIV: begin
        if (ge) begin
          rem_d = rem_q - SUM_W'(dsh_q);
        end
        quo_d  = {quo_q[LEVEL_W-2:0], ge};
        dsh_d  = dsh_q >> 1;
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          state_d = BACK_NORM;
        end
      end
      BACK_NORM: begin
        if (v[V_W-1]) begin
          mant_d = {1'b1, {(FRAC_W-1){1'b0}}};
        end else begin
          mant_d = vsh[FRAC_W-1:0];
        end
        log_d   = {e, {FRAC_W{1'b0}}};
        step_d  = '1;
        state_d = BACK_SQR;
      end
      BACK_SQR: begin
        mant_d = sq[2*FRAC_W-1] ? sq[2*FRAC_W-1 -: FRAC_W] : sq[2*FRAC_W-2 -: FRAC_W];
        log_d  = {log_q[LOG_W-1:FRAC_W], log_q[FRAC_W-2:0], sq[2*FRAC_W-1]};
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          state_d = BACK_GAIN;
        end
      end
      BACK_GAIN: begin
        prod_d  = PROD_W'(log_q) * PROD_W'(HEIGHT_GAIN);
        state_d = BACK_OUT;
      end
      BACK_OUT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = BACK_IDLE;
        end
      end
      default: state_d = BACK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BACK_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quo_q  <= quo_d;
    idx_q  <= idx_d;
    last_q <= last_d;
    mant_q <= mant_d;
    log_q  <= log_d;
    prod_q <= prod_d;
  end

endmodule
`default_nettype wire

// ===== sv/spectrum_band_averager_core.sv =====
// Top level of the spectrum band averager: config registers, front end, job queue, back end.
// Input: one bin per cycle while the job queue has room; a bin that closes a band stalls the input
//   while the front end forms the next edge (square, then scale).
// In the back end each band runs a 1-bit-per-cycle divide and 16 squarings;
//   a 4-deep job queue absorbs bursts of bands, a 2-deep result queue decouples the output.
// Reset (async, active low): band_count 16, spacing_factor 1, pass state and queues cleared.
`timescale 1ns / 1ps
`default_nettype none
module spectrum_band_averager_core #(
  parameter int unsigned MAX_BANDS = sba_pkg::MAX_BANDS_DEF,
  parameter int unsigned MAG_WIDTH = sba_pkg::MAG_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sba_pkg::in_t                  in_data_i,
  input  wire logic                          push,
  output logic                               full,
  output sba_pkg::out_t                      out_data_o,
  output logic                               empty,
  input  wire logic                          pop,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sba_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [sba_pkg::PDATA_W-1:0]   pwdata,
  output logic      [sba_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);
  import sba_pkg::*;

  logic [BAND_COUNT_W-1:0] band_count_q;
  logic [SPACING_W-1:0]    spacing_q;
  reg_idx_e                reg_idx;
  logic                    cfg_write;

  job_t job_in, job_head;
  logic job_push, job_full, job_pop, job_empty;
  logic front_busy;
  out_t res;
  logic res_push, res_full;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = reg_idx_e'(paddr[2]);

  always_comb begin
    unique case (reg_idx)
      REG_BAND_COUNT: prdata = PDATA_W'(band_count_q);
      REG_SPACING:    prdata = PDATA_W'(spacing_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_count_q <= BAND_COUNT_RST;
      spacing_q    <= SPACING_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_BAND_COUNT: band_count_q <= pwdata[BAND_COUNT_W-1:0];
        REG_SPACING:    spacing_q    <= pwdata[SPACING_W-1:0];
        default: ;
      endcase
    end
  end

  sba_front #(
    .MAX_BANDS(MAX_BANDS),
    .MAG_WIDTH(MAG_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .push_i      (push),
    .full_o      (full),
    .band_count_i(band_count_q),
    .spacing_i   (spacing_q),
    .job_o       (job_in),
    .job_push_o  (job_push),
    .job_full_i  (job_full),
    .busy_o      (front_busy)
  );

  sba_fifo #(
    .WIDTH($bits(job_t)),
    .DEPTH(JOB_DEPTH)
  ) u_job_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .wdata_i(job_in),
    .full_o (job_full),
    .pop_i  (job_pop),
    .rdata_o(job_head),
    .empty_o(job_empty)
  );

  sba_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job_head),
    .job_empty_i(job_empty),
    .job_pop_o  (job_pop),
    .res_o      (res),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  sba_fifo #(
    .WIDTH($bits(out_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(out_data_o),
    .empty_o(empty)
  );

  a_job_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !job_full)
    else $error("job pushed into a full queue");

  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_busy |-> full)
    else $error("input open while edge computation runs");

  a_busy_after_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(front_busy) |-> $past(job_push))
    else $error("edge computation started without a band transaction");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for spectrum_band_averager_core: directed and random bin streams checked per band.
`timescale 1ns / 1ps
module tb_top;
  import sba_pkg::*;

  localparam int unsigned MAX_BANDS   = MAX_BANDS_DEF;
  localparam int unsigned SETTLE      = 60;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned RANDOM_BINS = 500;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  in_t                 bin_item = '0;
  logic                push = 1'b0;
  logic                full;
  out_t                band_result;
  logic                empty;
  logic                pop = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // band averager model state
  int unsigned       cfg_band_count = BAND_COUNT_RST;
  int unsigned       cfg_spacing = SPACING_RST;
  int unsigned       bin_pos;
  int unsigned       cur_band;
  longint unsigned   band_edge_pos;
  longint unsigned   prev_edge_pos;
  longint unsigned   band_sum;
  bit                pos_saturated;
  out_t              expected_bands_q[$];
  out_t              oldest_band;

  int unsigned       live_bins = 0;
  int unsigned       mismatches = 0;
  int unsigned       cycle_count = 0;
  int unsigned       hold_req = 0;
  bit                tx_idle = 1'b1;
  bit                rx_idle = 1'b1;

  spectrum_band_averager_core u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_data_i  (bin_item),
    .push       (push),
    .full       (full),
    .out_data_o (band_result),
    .empty      (empty),
    .pop        (pop),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 20) $display("%0t ERROR: %s", $time, msg);
  endtask

  // 0.2*log10(v) in Q0.16 via log2 by repeated squaring
  function automatic logic [BAR_W-1:0] bar_height_of(input int unsigned v);
    int unsigned     e;
    int unsigned     t;
    longint unsigned m;
    longint unsigned l;
    longint unsigned p;
    e = 0;
    t = v;
    while (t > 1) begin
      t = t >> 1;
      e++;
    end
    if (e <= 15) m = 64'(v) << (15 - e);
    else m = 64'(v) >> (e - 15);
    l = 64'(e) << 16;
    for (int k = 15; k >= 0; k--) begin
      m = (m * m) >> 15;
      if (m >= 65536) begin
        m = m >> 1;
        l = l | (64'd1 << k);
      end
    end
    p = (l * 64'(HEIGHT_GAIN) + (64'd1 << 23)) >> ROUND_SHIFT;
    return p[BAR_W-1:0];
  endfunction

  function automatic void restart_pass();
    bin_pos = 0;
    cur_band = 0;
    band_edge_pos = 0;
    prev_edge_pos = 0;
    band_sum = 0;
    pos_saturated = 1'b0;
  endfunction

  function automatic int unsigned effective_bands();
    if (cfg_band_count < 1) return 1;
    if (cfg_band_count > MAX_BANDS) return MAX_BANDS;
    return cfg_band_count;
  endfunction

  function automatic void accumulate_bin(input in_t item);
    int unsigned     eff;
    longint unsigned sp;
    longint unsigned div;
    longint unsigned lvl;
    out_t            r;
    eff = effective_bands();
    sp = (cfg_spacing == 0) ? 1 : cfg_spacing;
    if (!pos_saturated && cur_band < eff) begin
      live_bins++;
      band_sum = band_sum + item.magnitude;
      if (band_sum > 64'hFFFF_FFFF) band_sum = 64'hFFFF_FFFF;
      if (64'(bin_pos) == band_edge_pos) begin
        div = (cur_band == 0) ? 1 : band_edge_pos - prev_edge_pos;
        if (div == 0 || band_edge_pos < prev_edge_pos) div = 1;
        lvl = band_sum / div;
        if (lvl > 65535) lvl = 65535;
        r.band_index = BAND_IDX_W'(cur_band);
        r.band_level = LEVEL_W'(lvl);
        r.bar_height = bar_height_of(int'(lvl) + 1);
        r.last_band = (cur_band + 1 == eff);
        expected_bands_q.push_back(r);
        band_sum = item.magnitude;
        prev_edge_pos = band_edge_pos;
        cur_band++;
        band_edge_pos = sp * 64'(cur_band) * 64'(cur_band);
      end
    end
    if (!pos_saturated) begin
      if (bin_pos >= 65535) pos_saturated = 1'b1;
      else bin_pos++;
    end
    if (item.last_bin) restart_pass();
  endfunction

  function automatic logic [MAG_W-1:0] random_magnitude();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return MAG_W'($urandom);
    endcase
  endfunction

  // all tasks below are entered and left at a falling edge
  task automatic send_bin(input logic [MAG_W-1:0] mag, input logic last_flag);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    bin_item.magnitude = mag;
    bin_item.last_bin = last_flag;
    push = 1'b1;
    do @(posedge clk); while (full);
    accumulate_bin(bin_item);
    @(negedge clk);
  endtask

  task automatic send_pass(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_bin(random_magnitude(), i == len - 1);
  endtask

  task automatic wait_drained();
    push = 1'b0;
    while (expected_bands_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_register(input reg_idx_e idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] mask;
    logic [PDATA_W-1:0] readback;
    mask = (idx == REG_BAND_COUNT) ? PDATA_W'(7'h7F) : PDATA_W'(11'h7FF);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = PADDR_W'(int'(idx) * 4);
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_BAND_COUNT) cfg_band_count = value & mask;
    else cfg_spacing = value & mask;
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (readback !== (value & mask))
      report($sformatf("register %s read 0x%0h, want 0x%0h", idx.name(), readback,
                       value & mask));
  endtask

  task automatic configure(input int unsigned bands, input int unsigned spacing);
    write_register(REG_BAND_COUNT, bands);
    write_register(REG_SPACING, spacing);
  endtask

  task automatic test_directed();
    logic [MAG_W-1:0] pass_a[13];
    pass_a = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hAAAA, 16'h5555,
               16'hFFFF, 16'h0001, 16'h8000, 16'h1234, 16'h7FFF, 16'hC3C3};
    // unfinished band at pass end gives no result
    for (int i = 0; i < 13; i++) send_bin(pass_a[i], i == 12);
    send_bin(16'h5555, 1'b1);
    send_bin(16'h0000, 1'b0);
    send_bin(16'h0000, 1'b1);
    // saturated level
    for (int i = 0; i < 5; i++) send_bin(16'hFFFF, i == 4);
    wait_drained();
  endtask

  task automatic test_band_count_limits();
    configure(0, 1);
    send_pass(4);
    wait_drained();
    configure(127, 0);
    send_pass(40);
    wait_drained();
    configure(64, 1);
    send_pass(20);
    wait_drained();
  endtask

  task automatic test_wide_spacing();
    configure(2, 300);
    send_pass(305);
    wait_drained();
  endtask

  task automatic test_midpass_write();
    configure(16, 1);
    for (int i = 0; i < 11; i++) send_bin(random_magnitude(), 1'b0);
    wait_drained();
    configure(6, 3);
    for (int i = 11; i <= 80; i++) send_bin(random_magnitude(), i == 80);
    wait_drained();
    configure(16, 1);
    for (int i = 0; i < 11; i++) send_bin(random_magnitude(), 1'b0);
    wait_drained();
    write_register(REG_BAND_COUNT, 2);
    send_pass(5);
    wait_drained();
  endtask

  task automatic test_backpressure();
    configure(16, 1);
    hold_req = 600;
    tx_idle = 1'b0;
    send_pass(230);
    tx_idle = 1'b1;
    wait_drained();
  endtask

  task automatic test_random();
    int unsigned     target;
    int unsigned     bands;
    int unsigned     spacing;
    int unsigned     eff;
    longint unsigned last_edge;
    int unsigned     len;
    int unsigned     kind;
    target = live_bins + RANDOM_BINS;
    while (live_bins < target) begin
      wait_drained();
      case ($urandom_range(0, 7))
        0: bands = 0;
        1: bands = 1;
        default: bands = $urandom_range(2, 12);
      endcase
      spacing = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3);
      configure(bands, spacing);
      rx_idle = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 4)) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        eff = effective_bands();
        last_edge = 64'((cfg_spacing == 0) ? 1 : cfg_spacing) * (eff - 1) * (eff - 1);
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
          send_pass(int'(last_edge) + 1 + $urandom_range(0, 4));
        end else if (kind <= 8) begin
          send_pass($urandom_range(1, int'(last_edge) + 1));
        end else begin
          len = $urandom_range(1, 20);
          for (int unsigned i = 0; i < len; i++)
            send_bin(random_magnitude(), $urandom_range(0, 3) == 0);
          send_bin(random_magnitude(), 1'b1);
        end
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // result side: random stalls, plus a long hold-off when requested
  initial begin : result_drain
    int unsigned stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
        pop = 1'b0;
        repeat (stall) @(negedge clk);
      end
      stall = rx_idle ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        pop = 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_bands_q.size() == 0) begin
        report($sformatf("unexpected band %0d level %0d bar %0d last %0b",
                         band_result.band_index, band_result.band_level,
                         band_result.bar_height, band_result.last_band));
      end else begin
        oldest_band = expected_bands_q.pop_front();
        if (band_result !== oldest_band)
          report($sformatf("band got %0d/%0d/%0d/%0b want %0d/%0d/%0d/%0b",
                           band_result.band_index, band_result.band_level,
                           band_result.bar_height, band_result.last_band,
                           oldest_band.band_index, oldest_band.band_level,
                           oldest_band.bar_height, oldest_band.last_band));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    restart_pass();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_band_count_limits();
    test_wide_spacing();
    test_midpass_write();
    test_backpressure();
    test_random();
    push = 1'b0;
    while (expected_bands_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
sv/sba_pkg.sv
sv/sba_fifo.sv
sv/sba_front.sv
sv/sba_back.sv
sv/spectrum_band_averager_core.sv
tb/tb_top.sv
